// ===== src/skt_pkg.sv =====
// Shared types, constants and helpers for the sorted key table update core.
// Used by skt_cell, skt_ctrl and sorted_key_table_update_core.
package skt_pkg;

   localparam int CAPACITY = 256;
   localparam int KEY_W = 32;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int FIELD_W = 9;

   localparam logic ACT_INSERT = 1'b0;
   localparam logic ACT_DELETE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   // Phase of the request as it travels along the row of cells
   typedef enum logic [3:0] {
      PH_SEEK = 4'b0001,
      PH_UP   = 4'b0010,
      PH_DOWN = 4'b0100,
      PH_DONE = 4'b1000
   } phase_type;

   typedef struct packed {
      logic             active;
      logic             action;
      phase_type        phase;
      status_type       status;
      logic [KEY_W-1:0] key;
      logic [KEY_W-1:0] carry;
      logic [CNT_W-1:0] pos;
   } token_type;

   // Fit a count-width value into a 9-bit result field (truncate or zero extend)
   function automatic logic [FIELD_W-1:0] to_field(input logic [CNT_W-1:0] v);
      logic [FIELD_W-1:0] r;
      r = '0;
      for (int b = 0; b < FIELD_W; b++) begin
         if (b < CNT_W) begin
            r[b] = v[b];
         end
      end
      return r;
   endfunction

endpackage

// ===== src/sorted_key_table_update_core.sv =====
// Sorted key table update core: a row of CAPACITY cells keeps keys ascending.
// A request is registered at the head, walks the cell row one cell per cycle and
// ends in a pending result register. One request is in flight; a new request is
// taken once the last result has left the pending register, even while the response waits.
// Reset (synchronous, active high) empties the table; no clearing pass is needed.
// Depends on skt_pkg, skt_cell and skt_ctrl.
module sorted_key_table_update_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic [0:0]  req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [1:0] status, [10:2] position, [19:11] count
);
   import skt_pkg::*;

   token_type        tok [CAPACITY+1];
   logic [KEY_W-1:0] cell_key [CAPACITY+1];
   logic             cell_valid [CAPACITY+1];

   // end of row: nothing to pull down
   assign cell_key[CAPACITY] = '0;
   assign cell_valid[CAPACITY] = 1'b0;

   skt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser[0]),
      .req_key    (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .tok_head   (tok[0]),
      .tok_tail   (tok[CAPACITY])
   );

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      skt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .tok_in    (tok[i]),
         .tok_out   (tok[i+1]),
         .nxt_key   (cell_key[i+1]),
         .nxt_valid (cell_valid[i+1]),
         .key       (cell_key[i]),
         .valid     (cell_valid[i])
      );
   end

endmodule

// ===== src/skt_cell.sv =====
// One table cell: holds a key and its valid bit, handles the request passing by
// and hands the request on to the next cell. Depends on skt_pkg.
module skt_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  skt_pkg::token_type       tok_in,
   output skt_pkg::token_type       tok_out,
   input  logic [skt_pkg::KEY_W-1:0] nxt_key,
   input  logic                     nxt_valid,
   output logic [skt_pkg::KEY_W-1:0] key,
   output logic                     valid
);
   import skt_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic             valid_ff, valid_in;
   token_type        tok_ff, tok_in_c;

   always_comb begin
      key_in = key_ff;
      valid_in = valid_ff;
      tok_in_c = tok_in;
      if (tok_in.active) begin
         case (tok_in.phase)
            PH_SEEK: begin
               if (valid_ff && (key_ff < tok_in.key)) begin
                  tok_in_c.pos = tok_in.pos + CNT_W'(1);
               end else if (tok_in.action == ACT_INSERT) begin
                  // take the new key, push the old one up the row
                  key_in = tok_in.key;
                  valid_in = 1'b1;
                  tok_in_c.carry = key_ff;
                  tok_in_c.phase = valid_ff ? PH_UP : PH_DONE;
               end else if (valid_ff && (key_ff == tok_in.key)) begin
                  key_in = nxt_key;
                  valid_in = nxt_valid;
                  tok_in_c.phase = PH_DOWN;
               end else begin
                  tok_in_c.status = STATUS_NOT_FOUND;
                  tok_in_c.phase = PH_DONE;
               end
            end
            PH_UP: begin
               key_in = tok_in.carry;
               valid_in = 1'b1;
               tok_in_c.carry = key_ff;
               if (!valid_ff) begin
                  tok_in_c.phase = PH_DONE;
               end
            end
            PH_DOWN: begin
               // pull the neighbor's entry down
               key_in = nxt_key;
               valid_in = nxt_valid;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff.active <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         tok_ff <= tok_in_c;
      end
   end

   assign tok_out = tok_ff;
   assign key = key_ff;
   assign valid = valid_ff;

endmodule

// ===== src/skt_ctrl.sv =====
// Request and response handshakes, entry count and result formatting for the
// sorted key table update core. Depends on skt_pkg.
module skt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_action,
   input  logic [skt_pkg::KEY_W-1:0] req_key,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   output skt_pkg::token_type  tok_head,
   input  skt_pkg::token_type  tok_tail
);
   import skt_pkg::*;

   token_type          head_ff, head_in;
   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [23:0]        pend_data_ff, pend_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [23:0]        rsp_data_ff, rsp_data_in;
   logic               accept;
   status_type         fin_status;
   logic [CNT_W-1:0]   fin_pos;

   assign req_tready = !busy_ff && !pend_valid_ff;
   assign accept = req_tvalid && req_tready;

   always_comb begin
      fin_status = tok_tail.status;
      fin_pos = tok_tail.pos;
      // a delete that ran off the end of the row found nothing
      if (tok_tail.phase == PH_SEEK) begin
         fin_status = STATUS_NOT_FOUND;
      end
      if (fin_status != STATUS_DONE) begin
         fin_pos = '0;
      end
   end

   always_comb begin
      head_in = head_ff;
      head_in.active = 1'b0;
      busy_in = busy_ff;
      count_in = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_data_in = pend_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;

      if (accept) begin
         head_in.active = 1'b1;
         head_in.action = req_action;
         head_in.key = req_key;
         head_in.carry = '0;
         head_in.pos = '0;
         if ((req_action == ACT_INSERT) && (count_ff == CNT_W'(CAPACITY))) begin
            head_in.status = STATUS_FULL;
            head_in.phase = PH_DONE;
         end else begin
            head_in.status = STATUS_DONE;
            head_in.phase = PH_SEEK;
         end
         busy_in = 1'b1;
      end

      if (tok_tail.active) begin
         if (fin_status == STATUS_DONE) begin
            count_in = (tok_tail.action == ACT_INSERT) ? count_ff + CNT_W'(1)
                                                       : count_ff - CNT_W'(1);
         end
         pend_data_in = {4'b0, to_field(count_in), to_field(fin_pos), fin_status};
         pend_valid_in = 1'b1;
         busy_in = 1'b0;
      end

      // move the finished result to the output register
      if (pend_valid_ff && (!rsp_valid_ff || rsp_tready)) begin
         rsp_data_in = pend_data_ff;
         rsp_valid_in = 1'b1;
         pend_valid_in = 1'b0;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      pend_data_ff <= pend_data_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         head_ff.active <= 1'b0;
         busy_ff <= 1'b0;
         count_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff <= head_in;
         busy_ff <= busy_in;
         count_ff <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign tok_head = head_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== verif/skt_checker.sv =====
// Request/response checker for sorted_key_table_update_core: keeps its own sorted
// key table, predicts status, position and count per request and compares them.
// Depends on skt_pkg for widths, action codes and status codes.
`timescale 1ns / 1ps

module skt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] key
   input  logic [0:0]  req_tuser,   // [0] action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [1:0] status, [10:2] position, [19:11] count
   output int          fail_count,
   output int          pending
);
   import skt_pkg::*;

   typedef struct packed {
      status_type         status;
      logic [FIELD_W-1:0] position;
      logic [FIELD_W-1:0] count;
   } table_result_type;

   logic [KEY_W-1:0] held_keys [CAPACITY];
   int unsigned      held;
   table_result_type expected_results [$];
   int               errors;

   // Apply one insert or delete to the shadow table and return its result
   task automatic apply_update(input logic act, input logic [KEY_W-1:0] k,
                               output table_result_type res);
      int unsigned at;
      int unsigned i;
      at = 0;
      while (at < held && held_keys[at] < k) at++;
      res.status   = STATUS_DONE;
      res.position = '0;
      if (act == ACT_INSERT) begin
         if (held >= CAPACITY) begin
            res.status = STATUS_FULL;
         end else begin
            for (i = held; i > at; i--) held_keys[i] = held_keys[i-1];
            held_keys[at] = k;
            held++;
            res.position = FIELD_W'(at);
         end
      end else begin
         if (at < held && held_keys[at] == k) begin
            for (i = at; i + 1 < held; i++) held_keys[i] = held_keys[i+1];
            held--;
            res.position = FIELD_W'(at);
         end else begin
            res.status = STATUS_NOT_FOUND;
         end
      end
      res.count = FIELD_W'(held);
   endtask

   task automatic report_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      table_result_type predicted;
      table_result_type oldest;
      if (reset) begin
         held = 0;
         expected_results.delete();
      end else begin
         // Sample the response first: a new request never answers in the same cycle
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: response with no request waiting, expected none actual %h",
                        $time, rsp_tdata);
               errors++;
            end else begin
               oldest = expected_results.pop_front();
               report_field("status", oldest.status, rsp_tdata[1:0]);
               report_field("position", oldest.position, rsp_tdata[10:2]);
               report_field("count", oldest.count, rsp_tdata[19:11]);
            end
         end
         if (req_tvalid && req_tready) begin
            apply_update(req_tuser[0], req_tdata, predicted);
            expected_results.insert(expected_results.size(), predicted);
         end
      end
      fail_count <= errors;
      pending    <= expected_results.size();
   end

endmodule

// ===== verif/tb.sv =====
// Testbench top for sorted_key_table_update_core: drives insert/delete requests
// with random gaps and response stalls, and reports the verdict of skt_checker.
// Depends on skt_pkg, skt_checker and the core.
`timescale 1ns / 1ps

module tb;
   import skt_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   int          fail_count;
   int          pending;

   logic [KEY_W-1:0] key_pool [$];
   int               ready_left = 0;
   int               stall_left = 0;

   // {action, key}
   localparam logic [32:0] DIRECTED [20] = '{
      {ACT_DELETE, 32'h0000_0005},
      {ACT_INSERT, 32'h0000_0000},
      {ACT_INSERT, 32'hFFFF_FFFF},
      {ACT_INSERT, 32'h8000_0000},
      {ACT_INSERT, 32'h8000_0000},
      {ACT_INSERT, 32'h7FFF_FFFF},
      {ACT_INSERT, 32'h0000_0001},
      {ACT_INSERT, 32'hFFFF_FFFE},
      {ACT_DELETE, 32'h8000_0000},
      {ACT_DELETE, 32'h8000_0000},
      {ACT_DELETE, 32'h8000_0000},
      {ACT_DELETE, 32'h0000_0000},
      {ACT_DELETE, 32'hFFFF_FFFF},
      {ACT_INSERT, 32'h0000_0005},
      {ACT_INSERT, 32'h0000_0005},
      {ACT_INSERT, 32'h0000_0005},
      {ACT_DELETE, 32'h0000_0004},
      {ACT_DELETE, 32'h0000_0006},
      {ACT_INSERT, 32'hAAAA_AAAA},
      {ACT_INSERT, 32'h5555_5555}
   };

   localparam int PHASE_LEN [5]   = '{400, 300, 400, 400, 400};
   localparam int INSERT_PCT [5]  = '{92, 50, 8, 92, 8};

   sorted_key_table_update_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   skt_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 4);
      if (r < 95) return $urandom_range(20, 60);
      return $urandom_range(200, 300);
   endfunction

   // Mix of duplicate-prone small keys, edge keys and full-range keys
   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 30) return KEY_W'($urandom_range(0, 15));
      if (r < 40) begin
         case ($urandom_range(0, 4))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFE;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   // Present one request after an optional idle gap and hold it until accepted
   task automatic send_request(input logic act, input logic [KEY_W-1:0] k);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= k;
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold off until every outstanding response has been checked
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Response side: alternate ready stretches and stalls, some long
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (ready_left > 0) begin
         rsp_tready <= 1'b1;
         ready_left--;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(300, 800)
                                                  : $urandom_range(1, 8);
         case ($urandom_range(0, 9))
            0:       stall_left = $urandom_range(100, 400);
            1, 2, 3: stall_left = $urandom_range(4, 30);
            default: stall_left = $urandom_range(0, 3);
         endcase
      end
   end

   initial begin
      logic             act;
      logic [KEY_W-1:0] k;
      int               idx;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) send_request(DIRECTED[i][32], DIRECTED[i][31:0]);
      wait_drained();

      // Fill to full and past it, drain past empty, with mixed traffic between
      foreach (PHASE_LEN[p]) begin
         for (int n = 0; n < PHASE_LEN[p]; n++) begin
            act = ($urandom_range(0, 99) < INSERT_PCT[p]) ? ACT_INSERT : ACT_DELETE;
            k   = pick_key();
            if (act == ACT_INSERT) begin
               if (key_pool.size() < 600) key_pool.insert(key_pool.size(), k);
            end else if (key_pool.size() > 0 && $urandom_range(0, 99) < 75) begin
               idx = $urandom_range(0, key_pool.size() - 1);
               k   = key_pool[idx];
               key_pool.delete(idx);
            end
            send_request(act, k);
         end
         wait_drained();
      end

      repeat (CAPACITY + 10) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #60ms;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
